### sv/tde_pkg.sv
// Shared constants and types for the token dictionary expander.
`timescale 1ns / 1ps

package tde_pkg;

    localparam int MAX_TOKENS   = 4096;
    localparam int DICT_BYTES   = 65536;
    localparam int CHUNK_BYTES  = 8;
    localparam int MAX_CHUNKS   = 64;
    localparam int CHUNK_LIMIT  = MAX_CHUNKS * CHUNK_BYTES;

    localparam int REQ_W        = 2;
    localparam int DICT_ADDR_W  = 16;
    localparam int OFFSET_IDX_W = 13;
    localparam int OFFSET_W     = 17;
    localparam int TOKEN_W      = 12;
    localparam int LEN_W        = 10;
    localparam int TAKE_W       = 4;
    localparam int BIDX_W       = 3;
    localparam int RD_ADDR_W    = 18;
    localparam int POS_W        = 32;
    localparam int CHUNK_W      = CHUNK_BYTES * 8;

    localparam logic [REQ_W-1:0] REQ_WRITE_BYTE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_OFFSET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXPAND       = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART      = 2'd3;

    typedef struct packed {
        logic              clear;
        logic              insert;
        logic [BIDX_W-1:0] idx;
        logic [7:0]        byte_val;
    } asm_ctrl_t;

endpackage

### sv/tde_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### sv/tde_chunk_asm.sv
// Chunk assembler that shifts each fetched byte into its lane of the chunk word.
`timescale 1ns / 1ps

module tde_chunk_asm
    import tde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  asm_ctrl_t          ctrl,
    output logic [CHUNK_W-1:0] chunk
);

    logic [CHUNK_W-1:0] chunk_reg;
    logic [CHUNK_W-1:0] chunk_next;

    always_comb
    begin
        chunk_next = chunk_reg;
        if (ctrl.clear)
        begin
            chunk_next = '0;
        end
        else if (ctrl.insert)
        begin
            chunk_next = chunk_reg
                | ({{(CHUNK_W-8){1'b0}}, ctrl.byte_val} << {ctrl.idx, 3'b000});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
        end
        else
        begin
            chunk_reg <= chunk_next;
        end
    end

    assign chunk = chunk_reg;

endmodule

### sv/token_dictionary_expander.sv
// Top level of the token dictionary expander: sequencer, stores and output register.
`timescale 1ns / 1ps

// Load and restart items are handled in the idle state when accepted. A token
// item reads its two boundary offsets in turn from the single-port offset
// memory, then builds each chunk of n bytes one byte at a time, since the
// dictionary memory delivers one byte per cycle.
// The input is ready only between items, and each finished chunk waits in an
// output register so that the next chunk can be fetched meanwhile.
module token_dictionary_expander
    import tde_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [DICT_ADDR_W-1:0]  dict_addr,
    input  logic [7:0]              byte_value,
    input  logic [OFFSET_IDX_W-1:0] offset_index,
    input  logic [OFFSET_W-1:0]     offset_value,
    input  logic [TOKEN_W-1:0]      token_code,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHUNK_W-1:0]      chunk_data,
    output logic [TAKE_W-1:0]       chunk_bytes,
    output logic                    last_chunk,
    output logic [POS_W-1:0]        out_position,
    output logic                    truncated
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD1   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [OFFSET_W-1:0]    start_reg, start_next;
    logic [TOKEN_W-1:0]     tok_reg, tok_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       pos_reg, pos_next;
    logic                   cut_reg, cut_next;
    logic [TAKE_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [BIDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   rd_zero_reg, rd_zero_next;
    logic [POS_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHUNK_W-1:0]     out_data_reg;
    logic [TAKE_W-1:0]      out_bytes_reg;
    logic                   out_last_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic                   out_cut_reg;

    logic                   accept;
    logic                   slot_free;
    logic                   push;
    logic                   last;
    logic [LEN_W-1:0]       remain;
    logic [TAKE_W-1:0]      take;
    logic                   issue;
    logic [RD_ADDR_W-1:0]   rd_addr;
    logic                   rd_in_range;
    logic [OFFSET_W-1:0]    len_full;
    logic                   len_cut;

    logic                   off_en, off_we;
    logic [OFFSET_IDX_W-1:0] off_addr;
    logic [OFFSET_W-1:0]    off_rdata;
    logic                   dict_en, dict_we;
    logic [DICT_ADDR_W-1:0] dict_ram_addr;
    logic [7:0]             dict_rdata;
    asm_ctrl_t              asm_ctrl;
    logic [CHUNK_W-1:0]     chunk;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign push      = (state_reg == ST_PUSH) && slot_free;

    assign remain = len_reg - pos_reg;
    assign take   = (remain > LEN_W'(CHUNK_BYTES)) ? TAKE_W'(CHUNK_BYTES) : remain[TAKE_W-1:0];
    assign last   = (pos_reg + LEN_W'(take)) == len_reg;
    assign issue  = (state_reg == ST_FETCH) && (issue_cnt_reg < take);

    assign rd_addr     = RD_ADDR_W'(start_reg) + RD_ADDR_W'(pos_reg) + RD_ADDR_W'(issue_cnt_reg);
    assign rd_in_range = rd_addr < RD_ADDR_W'(DICT_BYTES);

    assign len_full = (off_rdata > start_reg) ? (off_rdata - start_reg) : '0;
    assign len_cut  = len_full > OFFSET_W'(CHUNK_LIMIT);

    always_comb
    begin
        off_en   = 1'b0;
        off_we   = 1'b0;
        off_addr = offset_index;
        if (accept && (req_type == REQ_WRITE_OFFSET))
        begin
            off_en = (offset_index <= OFFSET_IDX_W'(MAX_TOKENS));
            off_we = 1'b1;
        end
        else if (accept && (req_type == REQ_EXPAND))
        begin
            off_en   = 1'b1;
            off_addr = OFFSET_IDX_W'(token_code);
        end
        else if (state_reg == ST_RD1)
        begin
            off_en   = 1'b1;
            off_addr = OFFSET_IDX_W'(tok_reg) + OFFSET_IDX_W'(1);
        end
    end

    always_comb
    begin
        dict_en       = 1'b0;
        dict_we       = 1'b0;
        dict_ram_addr = dict_addr;
        if (accept && (req_type == REQ_WRITE_BYTE))
        begin
            dict_en = 1'b1;
            dict_we = 1'b1;
        end
        else if (issue)
        begin
            dict_en       = rd_in_range;
            dict_ram_addr = rd_addr[DICT_ADDR_W-1:0];
        end
    end

    tde_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (MAX_TOKENS + 1)
    ) u_offset_ram (
        .clk   (clk),
        .en    (off_en),
        .we    (off_we),
        .addr  (off_addr),
        .wdata (offset_value),
        .rdata (off_rdata)
    );

    tde_ram #(
        .WIDTH (8),
        .DEPTH (DICT_BYTES)
    ) u_dict_ram (
        .clk   (clk),
        .en    (dict_en),
        .we    (dict_we),
        .addr  (dict_ram_addr),
        .wdata (byte_value),
        .rdata (dict_rdata)
    );

    always_comb
    begin
        asm_ctrl.clear    = (state_reg == ST_IDLE) || push;
        asm_ctrl.insert   = rd_pend_reg;
        asm_ctrl.idx      = rd_idx_reg;
        asm_ctrl.byte_val = rd_zero_reg ? 8'd0 : dict_rdata;
    end

    tde_chunk_asm u_chunk_asm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (asm_ctrl),
        .chunk (chunk)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        tok_next       = tok_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        cut_next       = cut_reg;
        issue_cnt_next = issue_cnt_reg;
        count_next     = count_reg;
        rd_pend_next   = issue;
        rd_idx_next    = issue_cnt_reg[BIDX_W-1:0];
        rd_zero_next   = !rd_in_range;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (issue)
        begin
            issue_cnt_next = issue_cnt_reg + TAKE_W'(1);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                issue_cnt_next = '0;
                pos_next       = '0;
                if (accept)
                begin
                    unique case (req_type)
                        REQ_EXPAND:
                        begin
                            tok_next   = token_code;
                            state_next = ST_RD1;
                        end
                        REQ_RESTART:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD1:
            begin
                start_next = off_rdata;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cut_next   = len_cut;
                len_next   = len_cut ? LEN_W'(CHUNK_LIMIT) : len_full[LEN_W-1:0];
                state_next = (len_full == '0) ? ST_PUSH : ST_FETCH;
            end
            ST_FETCH:
            begin
                if (rd_pend_reg && (TAKE_W'(rd_idx_reg) == take - TAKE_W'(1)))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg + POS_W'(take);
                    pos_next       = pos_reg + LEN_W'(take);
                    issue_cnt_next = '0;
                    state_next     = last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        tok_reg     <= tok_next;
        len_reg     <= len_next;
        pos_reg     <= pos_next;
        cut_reg     <= cut_next;
        rd_idx_reg  <= rd_idx_next;
        rd_zero_reg <= rd_zero_next;
        if (push)
        begin
            out_data_reg  <= chunk;
            out_bytes_reg <= take;
            out_last_reg  <= last;
            out_pos_reg   <= count_reg;
            out_cut_reg   <= cut_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chunk_data   = out_data_reg;
    assign chunk_bytes  = out_bytes_reg;
    assign last_chunk   = out_last_reg;
    assign out_position = out_pos_reg;
    assign truncated    = out_cut_reg;

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chunk_bytes <= TAKE_W'(CHUNK_BYTES)))
        else $error("Chunk holds more bytes than a chunk can carry.");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (chunk_bytes == '0)) |-> last_chunk)
        else $error("An empty chunk is not marked as the last chunk.");

    a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rd_pend_reg)
        else $error("A dictionary read is in flight while the block is idle.");

    a_token_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_EXPAND)) |=> (state_reg == ST_RD1))
        else $error("A token item did not start its offset lookup.");

    a_push_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !last) |=> (state_reg == ST_FETCH) && (pos_reg != '0))
        else $error("A non-final chunk did not lead to the next fetch.");

endmodule
